// ----- sv/crm_pkg.sv -----
// ----------------------------------------------------------------------------
// crm_pkg: shared types and constants for the centered rolling mean block
// Fixed-point constants of the dB/power conversion and the request/response
// structs between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package crm_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int LEVEL_W        = 16;
  localparam int HALF_W         = 5;
  localparam int POW_W          = 64;

  localparam logic [33:0] L2T_Q32  = 34'd14267572527;
  localparam logic [33:0] LN2_Q32  = 34'd2977044472;
  localparam logic [33:0] D10_Q20  = 34'd808071241;
  localparam logic [15:0] LEVEL_MAX = 16'd38400;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd12;
  localparam logic [4:0]  SQ_STEPS     = 5'd24;

  // L2T_Q32 split as 2560 * L2T_INT + L2T_REM, and 2^19/5 rounded up.
  localparam logic [22:0] L2T_INT = 23'd5573270;
  localparam logic [10:0] L2T_REM = 11'd1327;
  localparam logic [16:0] RCP5    = 17'd104858;

  typedef enum logic {
    OP_TO_POWER = 1'b0,
    OP_TO_DB    = 1'b1
  } crm_op_t;

  typedef struct packed {
    logic    start;
    crm_op_t op;
  } crm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } crm_rsp_t;

endpackage

// ----- sv/crm_math.sv -----
// ----------------------------------------------------------------------------
// crm_math: iterative dB/power conversion unit
// One shared multiplier and one bit-serial divider, run by a small sequencer,
// convert a clamped dB level to linear power or a window mean back to dB.
// ----------------------------------------------------------------------------
module crm_math #(
  parameter int RING_DEPTH = crm_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  crm_pkg::crm_req_t                req,
  input  logic [crm_pkg::LEVEL_W-1:0]      lv_i,
  input  logic [crm_pkg::POW_W-1:0]        sum_i,
  input  logic [$clog2(RING_DEPTH+1)-1:0]  cnt_i,
  output crm_pkg::crm_rsp_t                rsp,
  output logic [crm_pkg::POW_W-1:0]        result_o
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int DIVW  = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [18:0] {
    M_IDLE    = 19'h00001,
    M_P_MULE  = 19'h00002,
    M_P_MULR  = 19'h00004,
    M_P_RCP   = 19'h00008,
    M_P_E     = 19'h00010,
    M_P_Y     = 19'h00020,
    M_P_YSET  = 19'h00040,
    M_P_TMUL  = 19'h00080,
    M_P_TDIV  = 19'h00100,
    M_P_TACC  = 19'h00200,
    M_P_SHIFT = 19'h00400,
    M_D_CHK   = 19'h00800,
    M_D_NORM  = 19'h01000,
    M_D_SQM   = 19'h02000,
    M_D_SQA   = 19'h04000,
    M_D_LMUL  = 19'h08000,
    M_D_RND   = 19'h10000,
    M_DIV     = 19'h20000,
    M_DONE    = 19'h40000
  } mstate_t;

  mstate_t          state_r, div_ret_r;
  logic [67:0]      prod_r;
  logic [33:0]      mul_a, mul_b;
  logic [63:0]      div_num_r;
  logic [DIVW-1:0]  div_den_r, div_rem_r;
  logic [5:0]       div_cnt_r;
  logic [5:0]       n_r;
  logic [31:0]      y_r;
  logic [32:0]      term_r;
  logic [34:0]      psum_r;
  logic [3:0]       k_r;
  logic [63:0]      norm_r;
  logic [5:0]       sh_r;
  logic [30:0]      x_r;
  logic [23:0]      frac_r;
  logic [4:0]       i_r;
  logic [63:0]      result_r;
  logic [37:0]      eint_r;

  logic [DIVW:0]    div_trial;
  logic             div_ge;
  logic [25:0]      rsum;
  logic [16:0]      rx;
  logic [16:0]      q5;
  logic [31:0]      x2;
  logic [5:0]       p_pos;
  logic [29:0]      l_val;
  logic [59:0]      db_rnd;
  logic [39:0]      db40;
  logic [4:0]       rs;
  logic [63:0]      pow_shift;

  always_comb begin
    div_trial = {div_rem_r, div_num_r[63]};
    div_ge    = div_trial >= {1'b0, div_den_r};
    // Remainder part of the rounded divide by 2560: drop 512, then divide by
    // five with a reciprocal multiply that is exact for 17-bit values.
    rsum      = prod_r[25:0] + 26'd1280;
    rx        = rsum[25:9];
    q5        = prod_r[35:19];
    x2        = prod_r[61:30];
    p_pos     = 6'd63 - sh_r;
    l_val     = {p_pos - 6'd8, frac_r};
    db_rnd    = prod_r[59:0] + 60'd524288;
    db40      = db_rnd[59:20];
    rs        = 5'(6'd24 - n_r);
    if (n_r >= 6'd24) begin
      pow_shift = {29'b0, psum_r} << (n_r - 6'd24);
    end else begin
      pow_shift = ({29'b0, psum_r} + (64'd1 << (rs - 5'd1))) >> rs;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      M_P_MULE: begin
        mul_a = 34'(lv_i);
        mul_b = 34'(crm_pkg::L2T_INT);
      end
      M_P_MULR: begin
        mul_a = 34'(lv_i);
        mul_b = 34'(crm_pkg::L2T_REM);
      end
      M_P_RCP: begin
        mul_a = 34'(rx);
        mul_b = 34'(crm_pkg::RCP5);
      end
      M_P_Y: begin
        mul_a = {2'b0, div_num_r[31:0]};
        mul_b = crm_pkg::LN2_Q32;
      end
      M_P_TMUL: begin
        mul_a = {1'b0, term_r};
        mul_b = {2'b0, y_r};
      end
      M_D_SQM: begin
        mul_a = {3'b0, x_r};
        mul_b = {3'b0, x_r};
      end
      M_D_LMUL: begin
        mul_a = {4'b0, l_val};
        mul_b = crm_pkg::D10_Q20;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= M_IDLE;
      div_ret_r <= M_IDLE;
    end else begin
      case (state_r)
        M_IDLE: begin
          if (req.start) begin
            if (req.op == crm_pkg::OP_TO_DB) begin
              div_num_r <= sum_i;
              div_den_r <= DIVW'(cnt_i);
              div_rem_r <= '0;
              div_cnt_r <= '0;
              div_ret_r <= M_D_CHK;
              state_r   <= M_DIV;
            end else begin
              state_r <= M_P_MULE;
            end
          end
        end
        M_P_MULE: state_r <= M_P_MULR;
        M_P_MULR: begin
          eint_r  <= prod_r[37:0];
          state_r <= M_P_RCP;
        end
        M_P_RCP: state_r <= M_P_E;
        M_P_E: begin
          div_num_r <= {26'b0, eint_r + 38'(q5)};
          state_r   <= M_P_Y;
        end
        M_P_Y: begin
          n_r     <= div_num_r[37:32];
          state_r <= M_P_YSET;
        end
        M_P_YSET: begin
          y_r     <= prod_r[63:32];
          term_r  <= {1'b1, 32'b0};
          psum_r  <= {3'b0, 32'b0} | 35'(33'h100000000);
          k_r     <= 4'd1;
          state_r <= M_P_TMUL;
        end
        M_P_TMUL: state_r <= M_P_TDIV;
        M_P_TDIV: begin
          div_num_r <= {28'b0, prod_r[67:32]};
          div_den_r <= DIVW'(k_r);
          div_rem_r <= '0;
          div_cnt_r <= '0;
          div_ret_r <= M_P_TACC;
          state_r   <= M_DIV;
        end
        M_P_TACC: begin
          term_r <= div_num_r[32:0];
          psum_r <= psum_r + 35'(div_num_r[32:0]);
          if (k_r == crm_pkg::TAYLOR_TERMS) begin
            state_r <= M_P_SHIFT;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= M_P_TMUL;
          end
        end
        M_P_SHIFT: begin
          result_r <= pow_shift;
          state_r  <= M_DONE;
        end
        M_D_CHK: begin
          if (div_num_r <= 64'd256) begin
            result_r <= '0;
            state_r  <= M_DONE;
          end else begin
            norm_r  <= div_num_r;
            sh_r    <= '0;
            state_r <= M_D_NORM;
          end
        end
        M_D_NORM: begin
          // One bit per cycle until the leading one reaches the top.
          if (norm_r[63]) begin
            x_r     <= norm_r[63:33];
            frac_r  <= '0;
            i_r     <= '0;
            state_r <= M_D_SQM;
          end else begin
            norm_r <= {norm_r[62:0], 1'b0};
            sh_r   <= sh_r + 6'd1;
          end
        end
        M_D_SQM: state_r <= M_D_SQA;
        M_D_SQA: begin
          frac_r <= {frac_r[22:0], x2[31]};
          x_r    <= x2[31] ? x2[31:1] : x2[30:0];
          i_r    <= i_r + 5'd1;
          if (i_r == crm_pkg::SQ_STEPS - 5'd1) begin
            state_r <= M_D_LMUL;
          end else begin
            state_r <= M_D_SQM;
          end
        end
        M_D_LMUL: state_r <= M_D_RND;
        M_D_RND: begin
          result_r <= (db40 > 40'(crm_pkg::LEVEL_MAX)) ? 64'(crm_pkg::LEVEL_MAX)
                                                      : 64'(db40);
          state_r  <= M_DONE;
        end
        M_DIV: begin
          div_rem_r <= div_ge ? DIVW'(div_trial - {1'b0, div_den_r})
                              : div_trial[DIVW-1:0];
          div_num_r <= {div_num_r[62:0], div_ge};
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'd63) begin
            state_r <= div_ret_r;
          end
        end
        M_DONE: state_r <= M_IDLE;
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state_r != M_IDLE);
  assign rsp.done = (state_r == M_DONE);
  assign result_o = result_r;

endmodule

// ----- sv/centered_rolling_mean_db.sv -----
// ----------------------------------------------------------------------------
// centered_rolling_mean_db: centered moving average of dB levels
// Averages one column of dB samples in the power domain over rows i-h..i+h
// and returns each row's mean in dB.
// ----------------------------------------------------------------------------
// Usage: words arrive on the in_ channel (valid/ready) one row at a time; the
// row flagged in_last_in_column ends the column. Results leave on the out_
// channel (valid/ready) in row order, h rows behind the input; the last row
// flushes all pending rows, the final one carrying out_end_of_column.
// cfg_wr_en writes half_window (h) at once; it takes effect at the first row
// of the next column and is limited to (RING_DEPTH-1)/2.
// Throughput: one word at a time. The power conversion of a non-missing
// sample runs the bit-serial divider once per Taylor term, twelve in all.
// Each computed result takes one divide, a normalize and 24 squaring steps
// on the shared multiplier, plus a read and a subtract for each dropped row.
// in_ready is low meanwhile.
// A finished word waits in the output register while the next input is taken;
// if the receiver stalls, the sequencer holds before loading the next result.
// Reset (synchronous, rst_n low) empties the window, drops any output word and
// sets half_window to 1. The ring holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module centered_rolling_mean_db #(
  parameter int RING_DEPTH = crm_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [crm_pkg::LEVEL_W-1:0] in_level_db,
  input  logic                              in_is_missing,
  input  logic                              in_last_in_column,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [crm_pkg::LEVEL_W-1:0]       out_mean_db,
  output logic                              out_result_missing,
  output logic                              out_end_of_column,
  input  logic                              cfg_wr_en,
  input  logic [crm_pkg::HALF_W-1:0]        cfg_wr_data
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int AW    = $clog2(RING_DEPTH);
  localparam int OW    = CNT_W + 1;
  localparam int WW    = CNT_W + 6;
  localparam int HMAX  = (RING_DEPTH - 1) / 2;
  localparam logic [crm_pkg::HALF_W-1:0] HMAX_H =
    (HMAX > 31) ? 5'd31 : crm_pkg::HALF_W'(HMAX);
  localparam logic [AW-1:0] RP_LAST = AW'(RING_DEPTH - 1);

  typedef enum logic [11:0] {
    S_IDLE      = 12'h001,
    S_CONV      = 12'h002,
    S_CHKDROP   = 12'h004,
    S_DROP_RD   = 12'h008,
    S_DROP_SUB  = 12'h010,
    S_INSERT    = 12'h020,
    S_MAIN      = 12'h040,
    S_DRAIN     = 12'h080,
    S_EMIT      = 12'h100,
    S_EMIT_CALC = 12'h200,
    S_EMIT_OUT  = 12'h400,
    S_FINISH    = 12'h800
  } state_t;

  state_t                        state_r;
  logic [crm_pkg::HALF_W-1:0]    hw_r, h_r, rem_r;
  logic [crm_pkg::LEVEL_W-1:0]   lv_r;
  logic                          miss_r, last_r, eoc_r, ret_drain_r;
  logic [63:0]                   pw_r, sum_r;
  logic [CNT_W-1:0]              mcnt_r, wc_r, rr_r;
  logic [AW-1:0]                 rp_r;
  logic [15:0]                   res_db_r;
  logic                          res_miss_r;
  logic                          out_valid_r, out_miss_r, out_eoc_r;
  logic [15:0]                   out_db_r;
  logic [64:0]                   ring_mem [RING_DEPTH];
  logic [64:0]                   rd_data_r;

  logic                          in_acc, slot_free, mem_we;
  logic [15:0]                   lv_clamp;
  logic [crm_pkg::HALF_W-1:0]    h_lim, pend;
  logic [OW-1:0]                 old_tmp;
  logic [AW-1:0]                 old_addr;
  logic [WW-1:0]                 tgt_raw, tgt;
  crm_pkg::crm_req_t             math_req;
  crm_pkg::crm_rsp_t             math_rsp;
  logic [63:0]                   math_res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign mem_we    = (state_r == S_INSERT);

  always_comb begin
    if (in_level_db < 0) begin
      lv_clamp = '0;
    end else if (in_level_db > $signed({1'b0, crm_pkg::LEVEL_MAX})) begin
      lv_clamp = crm_pkg::LEVEL_MAX;
    end else begin
      lv_clamp = in_level_db;
    end
    h_lim   = (hw_r > HMAX_H) ? HMAX_H : hw_r;
    pend    = (WW'(rr_r) < WW'(h_r)) ? crm_pkg::HALF_W'(rr_r) : h_r;
    // Oldest row in the window sits win_count places behind the write pointer.
    old_tmp = OW'(rp_r) + OW'(RING_DEPTH) - OW'(wc_r);
    if (old_tmp >= OW'(RING_DEPTH)) begin
      old_tmp = old_tmp - OW'(RING_DEPTH);
    end
    old_addr = old_tmp[AW-1:0];
    tgt_raw  = WW'(h_r) + WW'(rem_r);
    tgt      = (tgt_raw > WW'(rr_r)) ? WW'(rr_r) : tgt_raw;
  end

  always_comb begin
    math_req.start = 1'b0;
    math_req.op    = crm_pkg::OP_TO_POWER;
    if (in_acc && !in_is_missing) begin
      math_req.start = 1'b1;
    end else if (state_r == S_EMIT && mcnt_r == '0 && wc_r != '0) begin
      math_req.start = 1'b1;
      math_req.op    = crm_pkg::OP_TO_DB;
    end
  end

  crm_math #(
    .RING_DEPTH(RING_DEPTH)
  ) u_math (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (math_req),
    .lv_i     (lv_r),
    .sum_i    (sum_r),
    .cnt_i    (wc_r),
    .rsp      (math_rsp),
    .result_o (math_res)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[rp_r] <= {miss_r, pw_r};
    end
    rd_data_r <= ring_mem[old_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= 5'd1;
    end else if (cfg_wr_en) begin
      hw_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT_OUT && slot_free) begin
      out_valid_r <= 1'b1;
      out_db_r    <= res_db_r;
      out_miss_r  <= res_miss_r;
      out_eoc_r   <= eoc_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      mcnt_r  <= '0;
      wc_r    <= '0;
      rr_r    <= '0;
      rp_r    <= '0;
      h_r     <= '0;
      rem_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            lv_r   <= lv_clamp;
            miss_r <= in_is_missing;
            last_r <= in_last_in_column;
            pw_r   <= '0;
            if (rr_r == '0) begin
              h_r <= h_lim;
            end
            state_r <= in_is_missing ? S_CHKDROP : S_CONV;
          end
        end
        S_CONV: begin
          if (math_rsp.done) begin
            pw_r    <= math_res;
            state_r <= S_CHKDROP;
          end
        end
        S_CHKDROP: begin
          ret_drain_r <= 1'b0;
          state_r     <= (WW'(wc_r) >= WW'({h_r, 1'b1})) ? S_DROP_RD : S_INSERT;
        end
        S_DROP_RD: state_r <= S_DROP_SUB;
        S_DROP_SUB: begin
          sum_r <= sum_r - rd_data_r[63:0];
          if (rd_data_r[64] && mcnt_r != '0) begin
            mcnt_r <= mcnt_r - 1'b1;
          end
          wc_r    <= wc_r - 1'b1;
          state_r <= ret_drain_r ? S_DRAIN : S_INSERT;
        end
        S_INSERT: begin
          sum_r  <= sum_r + pw_r;
          mcnt_r <= mcnt_r + CNT_W'(miss_r);
          wc_r   <= wc_r + 1'b1;
          rp_r   <= (rp_r == RP_LAST) ? '0 : rp_r + 1'b1;
          if (rr_r < CNT_W'(RING_DEPTH)) begin
            rr_r <= rr_r + 1'b1;
          end
          state_r <= S_MAIN;
        end
        S_MAIN: begin
          rem_r <= last_r ? pend : '0;
          if (WW'(rr_r) > WW'(h_r)) begin
            eoc_r   <= last_r && pend == '0;
            state_r <= S_EMIT;
          end else if (last_r && pend != '0) begin
            state_r <= S_DRAIN;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_DRAIN: begin
          // Shrink the window to the flushed row's span before emitting it.
          if (WW'(wc_r) > tgt) begin
            ret_drain_r <= 1'b1;
            state_r     <= S_DROP_RD;
          end else begin
            eoc_r   <= (rem_r == 5'd1);
            rem_r   <= rem_r - 5'd1;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (mcnt_r != '0 || wc_r == '0) begin
            res_db_r   <= '0;
            res_miss_r <= 1'b1;
            state_r    <= S_EMIT_OUT;
          end else begin
            state_r <= S_EMIT_CALC;
          end
        end
        S_EMIT_CALC: begin
          if (math_rsp.done) begin
            res_db_r   <= math_res[15:0];
            res_miss_r <= 1'b0;
            state_r    <= S_EMIT_OUT;
          end
        end
        S_EMIT_OUT: begin
          if (slot_free) begin
            state_r <= (rem_r == '0) ? S_FINISH : S_DRAIN;
          end
        end
        S_FINISH: begin
          if (last_r) begin
            sum_r  <= '0;
            mcnt_r <= '0;
            wc_r   <= '0;
            rr_r   <= '0;
            rp_r   <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mean_db        = out_db_r;
  assign out_result_missing = out_miss_r;
  assign out_end_of_column  = out_eoc_r;

  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= CNT_W'(RING_DEPTH))
    else $error("window count exceeds ring depth");

  a_miss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mcnt_r <= wc_r)
    else $error("missing count exceeds window count");

  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    math_rsp.done |-> (state_r == S_CONV || state_r == S_EMIT_CALC))
    else $error("arithmetic unit finished with no request pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready high right after a word was taken");

endmodule
